[rtl/shutter_synchronous_demodulator_assert.svh]
// ---------------------------------------------------------------------------
// assertion macros for the shutter synchronous demodulator
// ---------------------------------------------------------------------------
`ifndef SHUTTER_SYNCHRONOUS_DEMODULATOR_ASSERT_SVH
`define SHUTTER_SYNCHRONOUS_DEMODULATOR_ASSERT_SVH

// check a property on every rising edge outside reset
`define SSD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: property failed");

// check that a trigger implies a consequence in the same cycle
`define SSD_ASSERT_IMP(name, trig, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error("%m: implication failed");

`endif

[rtl/ssd_pkg.sv]
// ---------------------------------------------------------------------------
// ssd_pkg
// shared widths, constants and types of the shutter synchronous demodulator
// ---------------------------------------------------------------------------
package ssd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 20;
  localparam int EDGE_W      = 8;
  // magnitude of any sum stays below 2^(SAMPLE_BITS+COUNT_BITS)
  localparam int SUM_W       = SAMPLE_BITS + COUNT_BITS + 2;
  // quotient magnitude never exceeds the sample range
  localparam int QUO_W       = SAMPLE_BITS + 1;
  localparam int AVG_W       = QUO_W + 1;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = (SAMPLE_BITS > EDGE_W) ? SAMPLE_BITS : EDGE_W;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX       = {COUNT_BITS{1'b1}};
  localparam logic [EDGE_W-1:0]      EDGE_MAX        = {EDGE_W{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] MIDPOINT_RESET  = SAMPLE_BITS'(2048);
  localparam logic [EDGE_W-1:0]      THRESHOLD_RESET = EDGE_W'(10);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADC_MIDPOINT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_EMIT
  } ssd_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/ssd_div.sv]
// ---------------------------------------------------------------------------
// ssd_div
// restoring divider, one quotient bit per cycle, quotient known to fit QUO_W
// ---------------------------------------------------------------------------
module ssd_div import ssd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SUM_W-2:0]      dividend_i,
  input  logic [COUNT_BITS-1:0] divisor_i,
  output div_status_t           status_o,
  output logic [QUO_W-1:0]      quotient_o
);

  logic                  busy_q, busy_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [COUNT_BITS-1:0] den_q, den_d;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS+1:0] diff;
  logic                  fits;
  logic                  last_step;

  assign trial     = {rem_q, quo_q[QUO_W-1]};
  assign diff      = {1'b0, trial} - {2'b00, den_q};
  assign fits      = !diff[COUNT_BITS+1];
  assign last_step = busy_q && (step_q == STEP_W'(QUO_W - 1));

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      // upper bits start below the divisor since the quotient fits QUO_W
      rem_d  = dividend_i[SUM_W-2 -: COUNT_BITS];
      quo_d  = dividend_i[QUO_W-1:0];
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_d  = {quo_q[QUO_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = last_step;
  assign quotient_o    = quo_q;

endmodule

[rtl/shutter_synchronous_demodulator.sv]
// ---------------------------------------------------------------------------
// shutter_synchronous_demodulator
// lock-in averaging detector for a shuttered field sensor
// ---------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry one sample and the shutter
// level per transaction. output channel: out_valid_o / out_stall_i carry one
// window result (signed average, polarity, counter saturation) per transaction.
// configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 adc midpoint, 1 edge threshold); write only while the block is idle.
// a sample that closes no window passes through accept and accumulate only;
// a sample that closes a window goes on through divider start, divider run
// and emit before the result is loaded into the output register; the
// restoring divider produces one quotient bit per cycle.
// the output register holds one finished result, so the next sample is taken
// while the result waits; a second result waits in the emit state until the
// receiver takes the first, and no input is taken meanwhile.
// reset clears all sums and counters, sets the last shutter level to closed,
// the midpoint to 2048 and the threshold to 10; no result is pending.
// ---------------------------------------------------------------------------
module shutter_synchronous_demodulator import ssd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_BITS-1:0]  adc_sample_i,
  input  logic                    shutter_open_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [AVG_W-1:0] demod_average_o,
  output logic                    polarity_positive_o,
  output logic                    count_saturated_o
);

`include "shutter_synchronous_demodulator_assert.svh"

  ssd_state_e state_q, state_d;

  // configuration registers
  logic [SAMPLE_BITS-1:0] midpoint_q;
  logic [EDGE_W-1:0]      threshold_q;

  // captured transaction
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   open_q;

  // window state
  logic signed [SUM_W-1:0] sync_sum_q, sync_sum_d;
  logic signed [SUM_W-1:0] open_sum_q, open_sum_d;
  logic signed [SUM_W-1:0] closed_sum_q, closed_sum_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic [EDGE_W-1:0]       edges_q, edges_d;
  logic                    last_open_q, last_open_d;
  logic                    sat_q, sat_d;

  // output register
  logic                    out_valid_q;
  logic signed [AVG_W-1:0] avg_q;
  logic                    pol_q;
  logic                    osat_q;

  // control
  logic                    in_take;
  logic                    accum;
  logic                    div_start;
  logic                    emit_go;
  logic                    out_take;
  logic                    window_close;

  // datapath
  logic signed [SAMPLE_BITS:0] x_small;
  logic signed [SUM_W-1:0]     x_ext;
  logic signed [SUM_W-1:0]     sync_neg;
  logic [SUM_W-2:0]            magnitude;
  div_status_t                 div_stat;
  logic [QUO_W-1:0]            quotient;
  logic [AVG_W-1:0]            quo_ext;
  logic signed [AVG_W-1:0]     avg_next;

  // handshake decode
  assign in_take   = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accum     = (state_q == ST_ACCUM);
  assign div_start = (state_q == ST_DIV_START);
  assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // signed sample relative to the midpoint
  assign x_small = $signed({1'b0, sample_q}) - $signed({1'b0, midpoint_q});
  assign x_ext   = {{(SUM_W-SAMPLE_BITS-1){x_small[SAMPLE_BITS]}}, x_small};

  // window update in the accumulate cycle, window clear when a result is emitted
  always_comb begin
    sync_sum_d   = sync_sum_q;
    open_sum_d   = open_sum_q;
    closed_sum_d = closed_sum_q;
    count_d      = count_q;
    edges_d      = edges_q;
    last_open_d  = last_open_q;
    sat_d        = sat_q;
    if (accum) begin
      // a saturated counter freezes the sums so the average stays in range
      if (count_q != COUNT_MAX) begin
        if (open_q) begin
          sync_sum_d = sync_sum_q + x_ext;
          open_sum_d = open_sum_q + x_ext;
        end else begin
          sync_sum_d   = sync_sum_q - x_ext;
          closed_sum_d = closed_sum_q + x_ext;
        end
        count_d = count_q + 1'b1;
      end
      sat_d = sat_q || (count_d == COUNT_MAX);
      if (open_q != last_open_q) begin
        if (edges_q != EDGE_MAX) begin
          edges_d = edges_q + 1'b1;
        end
        last_open_d = open_q;
      end
    end else if (emit_go) begin
      // window clears, last shutter level is kept
      sync_sum_d   = '0;
      open_sum_d   = '0;
      closed_sum_d = '0;
      count_d      = '0;
      edges_d      = '0;
      sat_d        = 1'b0;
    end
  end

  assign window_close = (edges_d >= threshold_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_d = window_close ? ST_DIV_START : ST_IDLE;
      end
      ST_DIV_START: begin
        state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (div_stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // magnitude of the synchronous sum for the divider
  assign sync_neg  = -sync_sum_q;
  assign magnitude = sync_sum_q[SUM_W-1] ? sync_neg[SUM_W-2:0] : sync_sum_q[SUM_W-2:0];

  ssd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (magnitude),
    .divisor_i  (count_q),
    .status_o   (div_stat),
    .quotient_o (quotient)
  );

  // sign restored after the magnitude division, truncating toward zero
  assign quo_ext  = {1'b0, quotient};
  always_comb begin
    if (count_q == '0) begin
      avg_next = '0;
    end else if (sync_sum_q[SUM_W-1]) begin
      avg_next = $signed(-quo_ext);
    end else begin
      avg_next = $signed(quo_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      midpoint_q   <= MIDPOINT_RESET;
      threshold_q  <= THRESHOLD_RESET;
      sync_sum_q   <= '0;
      open_sum_q   <= '0;
      closed_sum_q <= '0;
      count_q      <= '0;
      edges_q      <= '0;
      last_open_q  <= 1'b0;
      sat_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sync_sum_q   <= sync_sum_d;
      open_sum_q   <= open_sum_d;
      closed_sum_q <= closed_sum_d;
      count_q      <= count_d;
      edges_q      <= edges_d;
      last_open_q  <= last_open_d;
      sat_q        <= sat_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ADC_MIDPOINT:   midpoint_q  <= cfg_data_i[SAMPLE_BITS-1:0];
          REG_EDGE_THRESHOLD: threshold_q <= cfg_data_i[EDGE_W-1:0];
          default: begin
          end
        endcase
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= adc_sample_i;
      open_q   <= shutter_open_i;
    end
    if (emit_go) begin
      avg_q  <= avg_next;
      pol_q  <= (open_sum_q > closed_sum_q);
      osat_q <= sat_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign demod_average_o     = avg_q;
  assign polarity_positive_o = pol_q;
  assign count_saturated_o   = osat_q;

  // saturation flag tracks the counter sitting at its maximum
  `SSD_ASSERT(a_sat_matches_count, sat_q == (count_q == COUNT_MAX))
  // the divider only runs while the sequencer waits on it
  `SSD_ASSERT_IMP(a_div_busy_state, div_stat.busy, state_q == ST_DIV_RUN)
  // a new result only appears after the emit state
  `SSD_ASSERT_IMP(a_result_from_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT)

endmodule

[dv/ssd_window_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ssd_window_checker
// watches the ports of the shutter synchronous demodulator, works out the
// window result that each accepted sample causes and compares every result
// transaction with the oldest one still owed
// ---------------------------------------------------------------------------
module ssd_window_checker import ssd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [SAMPLE_BITS-1:0]  adc_sample_i,
  input  logic                    shutter_open_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [AVG_W-1:0] demod_average_i,
  input  logic                    polarity_positive_i,
  input  logic                    count_saturated_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    polarity;
    logic                    saturated;
  } window_result_t;

  window_result_t window_results_q[$];

  // window state
  longint                 sync_acc;
  longint                 open_acc;
  longint                 closed_acc;
  logic [COUNT_BITS-1:0]  sample_cnt;
  logic [EDGE_W-1:0]      edge_cnt;
  logic                   last_open;
  logic                   sat_seen;
  // register copies
  logic [SAMPLE_BITS-1:0] midpoint;
  logic [EDGE_W-1:0]      threshold;
  int                     mismatches;

  function void clear_window();
    sync_acc   = 0;
    open_acc   = 0;
    closed_acc = 0;
    sample_cnt = '0;
    edge_cnt   = '0;
    sat_seen   = 1'b0;
  endfunction

  // fold one sample into the window, queue a result when the window closes
  function void accumulate(input logic [SAMPLE_BITS-1:0] sample, input logic open);
    longint         x;
    longint         avg;
    window_result_t res;
    x = longint'(sample) - longint'(midpoint);
    if (sample_cnt < COUNT_MAX) begin
      if (open) begin
        sync_acc = sync_acc + x;
        open_acc = open_acc + x;
      end else begin
        sync_acc   = sync_acc - x;
        closed_acc = closed_acc + x;
      end
      sample_cnt = sample_cnt + 1'b1;
      if (sample_cnt == COUNT_MAX) sat_seen = 1'b1;
    end else begin
      // counter pinned: the sample adds nothing to the sums
      sat_seen = 1'b1;
    end
    if (open != last_open) begin
      if (edge_cnt < EDGE_MAX) edge_cnt = edge_cnt + 1'b1;
      last_open = open;
    end
    if (edge_cnt >= threshold) begin
      avg = (sample_cnt == '0) ? 0 : sync_acc / longint'(sample_cnt);
      res.average   = avg[AVG_W-1:0];
      res.polarity  = (open_acc > closed_acc);
      res.saturated = sat_seen;
      window_results_q.push_back(res);
      clear_window();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    window_result_t owed;
    if (!rst_ni) begin
      clear_window();
      last_open  = 1'b0;
      midpoint   = MIDPOINT_RESET;
      threshold  = THRESHOLD_RESET;
      mismatches = 0;
      window_results_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ADC_MIDPOINT) midpoint = cfg_data_i[SAMPLE_BITS-1:0];
        else if (cfg_index_i == REG_EDGE_THRESHOLD) threshold = cfg_data_i[EDGE_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (window_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with none owed: avg %0d pol %0b sat %0b", $time,
                     demod_average_i, polarity_positive_i, count_saturated_i);
          mismatches++;
        end else begin
          owed = window_results_q.pop_front();
          if (owed.average !== demod_average_i || owed.polarity !== polarity_positive_i ||
              owed.saturated !== count_saturated_i) begin
            if (mismatches < 10)
              $display("%0t: result mismatch: expected avg %0d pol %0b sat %0b, got avg %0d pol %0b sat %0b",
                       $time, owed.average, owed.polarity, owed.saturated,
                       demod_average_i, polarity_positive_i, count_saturated_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) accumulate(adc_sample_i, shutter_open_i);
      mismatch_count_o <= mismatches;
      pending_o        <= window_results_q.size();
    end
  end

endmodule

[dv/shutter_synchronous_demodulator_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// shutter_synchronous_demodulator_test
// drives samples and shutter levels into the demodulator under a range of
// midpoint and threshold settings, with random gaps and receiver stalls;
// a checker beside the block predicts and compares every window result
// ---------------------------------------------------------------------------
module shutter_synchronous_demodulator_test;
  import ssd_pkg::*;

  localparam int CODE_MAX        = (1 << SAMPLE_BITS) - 1;
  localparam logic [SAMPLE_BITS-1:0] TOP_CODE = SAMPLE_BITS'(CODE_MAX);
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 400000;
  // a window-closing sample passes through the divider before its result is registered
  localparam int SETTLE_CYCLES   = 24;
  localparam int DRAIN_CYCLES    = 40;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [SAMPLE_BITS-1:0]  adc_sample_i;
  logic                    shutter_open_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [AVG_W-1:0] demod_average_o;
  logic                    polarity_positive_o;
  logic                    count_saturated_o;

  int          result_mismatches;
  int          results_pending;
  int unsigned cycle_count = 0;
  // shared between sender and receiver: steady drops all idling,
  // hold_off_req asks the receiver for one long stall
  bit          steady;
  bit          hold_off_req;

  shutter_synchronous_demodulator uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .adc_sample_i,
    .shutter_open_i,
    .out_valid_o,
    .out_stall_i,
    .demod_average_o,
    .polarity_positive_o,
    .count_saturated_o
  );

  ssd_window_checker window_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i          (in_stall_o),
    .adc_sample_i,
    .shutter_open_i,
    .out_valid_i         (out_valid_o),
    .out_stall_i,
    .demod_average_i     (demod_average_o),
    .polarity_positive_i (polarity_positive_o),
    .count_saturated_i   (count_saturated_o),
    .mismatch_count_o    (result_mismatches),
    .pending_o           (results_pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("shutter_synchronous_demodulator_test: done, errors");
      $finish;
    end
  end

  // receiver: random stall before each result transaction, one long hold-off
  // on request so that the output register and emit state fill up and the
  // block has to stall its input
  initial begin : receiver
    int stall_cycles;
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall_cycles = steady ? 0 : $urandom_range(0, 19);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_cycles += HOLD_OFF_CYCLES;
      end
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one input transaction: optional gap, then hold valid until taken;
  // with no gap valid stays high and only the payload moves on
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample, input logic open);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    adc_sample_i   <= sample;
    shutter_open_i <= open;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // wait until every owed result has gone out, then let the block settle
  task automatic wait_idle(input int settle);
    do @(posedge clk_i); while (results_pending != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // write both registers while the block is idle; the threshold word carries
  // random bits above the register width
  task automatic program_regs(input logic [SAMPLE_BITS-1:0] mid, input logic [EDGE_W-1:0] thr);
    logic [CFG_DATA_W-1:0] thr_word;
    in_valid_i <= 1'b0;
    wait_idle(SETTLE_CYCLES);
    thr_word             = CFG_DATA_W'($urandom);
    thr_word[EDGE_W-1:0] = thr;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ADC_MIDPOINT;
    cfg_data_i  <= CFG_DATA_W'(mid);
    @(posedge clk_i);
    cfg_index_i <= REG_EDGE_THRESHOLD;
    cfg_data_i  <= thr_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly a signal that follows the shutter around the midpoint, some
  // uniform noise and some rail codes
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] mid,
                                                         input logic open);
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom_range(0, CODE_MAX);
      2: v = $urandom_range(0, 1) ? CODE_MAX : 0;
      default: begin
        v = $urandom_range(0, 700);
        v = int'(mid) + (open ? v : -v) + int'($urandom_range(0, 40)) - 20;
      end
    endcase
    if (v < 0) v = 0;
    if (v > CODE_MAX) v = CODE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // one setting: square-wave shutter with random run lengths and the odd
  // single-sample glitch, samples correlated with the shutter level
  task automatic run_phase(input logic [SAMPLE_BITS-1:0] mid, input logic [EDGE_W-1:0] thr,
                           input int n_items, input int max_run, input bit squeeze,
                           input bit force_steady);
    int   i;
    int   run_left;
    logic lvl;
    logic open;
    program_regs(mid, thr);
    steady       = force_steady || (!squeeze && $urandom_range(0, 3) == 0);
    hold_off_req = squeeze;
    lvl          = 1'($urandom_range(0, 1));
    run_left     = 0;
    for (i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        lvl      = ~lvl;
        run_left = $urandom_range(1, max_run);
      end
      run_left--;
      open = ($urandom_range(0, 11) == 0) ? ~lvl : lvl;
      send_sample(pick_sample(mid, open), open);
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] rail_codes [11];
    int                     i;
    rst_ni = 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= REG_ADC_MIDPOINT;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    adc_sample_i   <= '0;
    shutter_open_i <= 1'b0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    rail_codes = '{12'd0, TOP_CODE, 12'd2048, TOP_CODE, 12'd0, 12'd1, TOP_CODE - 1'b1,
                   12'd2047, 12'd2049, TOP_CODE, 12'd0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: alternate the shutter from closed, the tenth change
    // closes the first window and the eleventh opens the next
    for (i = 0; i < 11; i++) send_sample(rail_codes[i], (i % 2) == 0);

    // midpoint at the bottom rail, one change closes each window: a negative
    // average, then a full-scale positive one
    program_regs('0, 8'd1);
    send_sample(TOP_CODE, 1'b0);
    send_sample(TOP_CODE, 1'b1);

    // midpoint at the top rail: negative samples, sign flips with the shutter
    program_regs(TOP_CODE, 8'd1);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);

    // threshold zero: every sample closes a window, level change or not
    program_regs(12'd2048, 8'd0);
    send_sample(12'd2048, 1'b1);
    send_sample(TOP_CODE, 1'b1);
    send_sample('0, 1'b0);

    // random part over a spread of settings
    run_phase(12'd2048, THRESHOLD_RESET, 160, 6, 1'b0, 1'b0);
    run_phase(SAMPLE_BITS'($urandom_range(0, CODE_MAX)), 8'd1, 140, 4, 1'b1, 1'b0);
    run_phase('0, 8'd2, 120, 5, 1'b0, 1'b0);
    run_phase(TOP_CODE, 8'd3, 120, 5, 1'b0, 1'b1);
    // widest threshold: fast shutter so that windows still close
    run_phase(12'd2048, 8'd255, 560, 1, 1'b0, 1'b0);
    run_phase(SAMPLE_BITS'($urandom_range(0, CODE_MAX)), 8'd0, 80, 3, 1'b0, 1'b0);
    run_phase(SAMPLE_BITS'($urandom_range(0, CODE_MAX)), EDGE_W'($urandom_range(1, 40)),
              200, 8, 1'b0, 1'b0);
    run_phase(SAMPLE_BITS'($urandom_range(0, CODE_MAX)), EDGE_W'($urandom_range(4, 16)),
              170, 3, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    wait_idle(DRAIN_CYCLES);
    if (result_mismatches == 0 && results_pending == 0)
      $display("shutter_synchronous_demodulator_test: done, clean");
    else
      $display("shutter_synchronous_demodulator_test: done, errors");
    $finish;
  end

endmodule
